/* src/q24a_pkg.sv */
// ----------------------------------------------------------------------------
// q24a_pkg: shared types and constants for the Q24.8 fixed-point ALU
// Holds opcode names, payload structs and the internal queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package q24a_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_item_t;

  // Classified work for the back end.
  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    out_item_t          direct;
  } work_t;

endpackage
`default_nettype wire

/* src/q24_8_fixed_point_alu.sv */
// An input transfer passes through the queue, pipe and skid to the output.
// Throughput: one item per cycle unless a full skid stalls, set by the fully
// pipelined multiply and the one-bit-per-stage divide pipeline.
// Reset: synchronous active-low rst_n empties the queue, pipeline and skid.
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu: Q24.8 fixed-point ALU
// Front end classifies, a queue decouples, the back end executes in order.
// ----------------------------------------------------------------------------
`default_nettype none
module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS = q24a_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  wire q24a_pkg::in_item_t in_item,
  output logic                 in_full,
  output q24a_pkg::out_item_t  out_item,
  output logic                 out_empty,
  input  wire                  out_pop
);

  q24a_pkg::work_t fw, qw;
  logic            q_empty, take;

  // Classify at the input; operations other than multiply and divide finish here.
  q24a_front #(.FRAC_BITS(FRAC_BITS)) u_front (.item(in_item), .work(fw));

  // Hold classified items until the back end can advance.
  q24a_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .push_data(fw), .full(in_full),
    .pop(take), .pop_data(qw), .empty(q_empty)
  );

  // Execute in order; the back end drains the queue, one a cycle unless stalled.
  q24a_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(!q_empty), .in_work(qw), .in_take(take),
    .out_item(out_item), .out_empty(out_empty), .out_pop(out_pop)
  );

endmodule
`default_nettype wire

/* src/q24a_front.sv */
// ----------------------------------------------------------------------------
// q24a_front: accept and classify
// Works out the operations other than multiply and divide, and tags those two.
// ----------------------------------------------------------------------------
`default_nettype none
module q24a_front #(
  parameter int FRAC_BITS = q24a_pkg::FRAC_BITS_DEF
) (
  input  wire q24a_pkg::in_item_t item,
  output q24a_pkg::work_t         work
);

  logic signed [31:0] a, b;
  logic               lt, eq;

  always_comb begin
    a  = item.operand_a;
    b  = item.operand_b;
    lt = a < b;
    eq = a == b;
    work.cls       = q24a_pkg::CLS_DIRECT;
    work.operand_a = a;
    work.operand_b = b;
    work.direct    = '0;
    case (item.opcode)
      q24a_pkg::OP_ADD:     work.direct.value = a + b;
      q24a_pkg::OP_SUB:     work.direct.value = a - b;
      q24a_pkg::OP_MUL:     work.cls = q24a_pkg::CLS_MUL;
      q24a_pkg::OP_DIV:     work.cls = q24a_pkg::CLS_DIV;
      q24a_pkg::OP_GT:      work.direct.compare_true = !lt && !eq;
      q24a_pkg::OP_LT:      work.direct.compare_true = lt;
      q24a_pkg::OP_GE:      work.direct.compare_true = !lt;
      q24a_pkg::OP_LE:      work.direct.compare_true = lt || eq;
      q24a_pkg::OP_EQ:      work.direct.compare_true = eq;
      q24a_pkg::OP_NE:      work.direct.compare_true = !eq;
      q24a_pkg::OP_INC:     work.direct.value = a + 32'sd1;
      q24a_pkg::OP_DEC:     work.direct.value = a - 32'sd1;
      q24a_pkg::OP_MIN:     work.direct.value = (lt || eq) ? a : b;
      q24a_pkg::OP_MAX:     work.direct.value = lt ? b : a;
      q24a_pkg::OP_TOINT:   work.direct.value = a >>> FRAC_BITS;
      q24a_pkg::OP_FROMINT: work.direct.value = a <<< FRAC_BITS;
      default:              work.direct = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/q24a_queue.sv */
// ----------------------------------------------------------------------------
// q24a_queue: short queue between front and back
// Circular buffer; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module q24a_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire q24a_pkg::work_t   push_data,
  output logic                   full,
  input  wire                    pop,
  output q24a_pkg::work_t        pop_data,
  output logic                   empty
);

  localparam int AW = q24a_pkg::QUEUE_AW;

  q24a_pkg::work_t mem [q24a_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full     = cnt_r == (AW+1)'(q24a_pkg::QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* src/q24a_back.sv */
// ----------------------------------------------------------------------------
// q24a_back: execute pipeline
// Pipelined multiply (4 partial products) and radix-2 pipelined divide,
// one item per cycle, with a stall-all pipeline and an output skid.
// ----------------------------------------------------------------------------
`default_nettype none
module q24a_back #(
  parameter int FRAC_BITS = q24a_pkg::FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire q24a_pkg::work_t   in_work,
  output logic                   in_take,
  output q24a_pkg::out_item_t    out_item,
  output logic                   out_empty,
  input  wire                    out_pop
);

  // Divide magnitude: |a| << FRAC_BITS, up to 32+FRAC_BITS bits.
  localparam int DW = 32 + FRAC_BITS;
  localparam int NS = DW + 3;           // div steps + setup + 2 finish

  typedef struct packed {
    logic                valid;
    q24a_pkg::cls_t      cls;
    q24a_pkg::out_item_t direct;
    logic [DW-1:0]       quo;           // quotient bits / dividend shifted
    logic [32:0]         rem;
    logic [31:0]         dvs;           // divisor magnitude
    logic                neg;
    logic [63:0]         acc;           // multiply accumulation
    logic [15:0]         ah, al, bh, bl;
  } stg_t;

  stg_t stg_r [NS];
  stg_t stg_nxt [NS];

  // Output skid: two entries.
  q24a_pkg::out_item_t sk_r [2];
  logic [1:0]          skv_r;
  logic                adv;
  stg_t                last;
  logic                sk_full;

  assign sk_full   = skv_r[1];
  // Advance unless a valid result would be stranded behind a full skid.
  assign adv       = !(stg_r[NS-1].valid && sk_full && !out_pop);
  assign in_take   = adv && in_valid;
  assign out_empty = !skv_r[0];
  assign out_item  = sk_r[0];
  assign last      = stg_r[NS-1];

  always_comb begin
    logic [31:0] ma, mb;
    logic [33:0] tr;
    logic [63:0] p;
    q24a_pkg::out_item_t res;
    for (int i = 0; i < NS; i++) stg_nxt[i] = stg_r[i];
    // Stage 0: load, magnitudes, multiply partial hi/lo split.
    stg_nxt[0]        = '0;
    stg_nxt[0].valid  = in_valid;
    stg_nxt[0].cls    = in_work.cls;
    stg_nxt[0].direct = in_work.direct;
    ma = in_work.operand_a[31] ? 32'(-in_work.operand_a) : in_work.operand_a;
    mb = in_work.operand_b[31] ? 32'(-in_work.operand_b) : in_work.operand_b;
    stg_nxt[0].quo = DW'({ma, FRAC_BITS'(0)});
    stg_nxt[0].dvs = mb;
    stg_nxt[0].neg = in_work.operand_a[31] ^ in_work.operand_b[31];
    stg_nxt[0].ah  = ma[31:16];
    stg_nxt[0].al  = ma[15:0];
    stg_nxt[0].bh  = mb[31:16];
    stg_nxt[0].bl  = mb[15:0];
    // Stage 1: multiply, forming the first two of the four 16x16 partial products.
    stg_nxt[1] = stg_r[0];
    stg_nxt[1].acc = {32'(stg_r[0].ah) * 32'(stg_r[0].bh),
                      32'(stg_r[0].al) * 32'(stg_r[0].bl)};
    // Divide steps share stages 1..DW.
    for (int i = 1; i <= DW; i++) begin
      if (i > 1) stg_nxt[i] = stg_r[i-1];
      tr = {stg_nxt[i].rem, stg_r[i-1].quo[DW-1]} - {2'b0, stg_r[i-1].dvs};
      if (!tr[33]) begin
        stg_nxt[i].rem = tr[32:0];
        stg_nxt[i].quo = {stg_r[i-1].quo[DW-2:0], 1'b1};
      end else begin
        stg_nxt[i].rem = {stg_r[i-1].rem[31:0], stg_r[i-1].quo[DW-1]};
        stg_nxt[i].quo = {stg_r[i-1].quo[DW-2:0], 1'b0};
      end
    end
    // Stages 2 and 3 each add in one of the two cross products.
    stg_nxt[2].acc = stg_r[1].acc
                   + {16'b0, 32'(stg_r[1].ah) * 32'(stg_r[1].bl), 16'b0};
    for (int i = 3; i <= DW; i++) stg_nxt[i].acc = stg_r[i-1].acc;
    stg_nxt[3].acc = stg_r[2].acc
                   + {16'b0, 32'(stg_r[2].al) * 32'(stg_r[2].bh), 16'b0};
    // Finish 1: sign fix, and the rounding half-LSB added for the multiply.
    stg_nxt[DW+1] = stg_r[DW];
    p = stg_r[DW].neg ? 64'(-stg_r[DW].acc) : stg_r[DW].acc;
    stg_nxt[DW+1].acc = p + (64'd1 << (FRAC_BITS - 1));
    stg_nxt[DW+1].quo = stg_r[DW].neg ? DW'(-stg_r[DW].quo) : stg_r[DW].quo;
    // Finish 2: select result.
    stg_nxt[DW+2] = stg_r[DW+1];
    res = stg_r[DW+1].direct;
    case (stg_r[DW+1].cls)
      q24a_pkg::CLS_MUL: res.value = 32'($signed(stg_r[DW+1].acc) >>> FRAC_BITS);
      q24a_pkg::CLS_DIV: begin
        if (stg_r[DW+1].dvs == '0) begin
          res.value = '0;
          res.divide_by_zero = 1'b1;
        end else begin
          res.value = 32'(stg_r[DW+1].quo);
        end
      end
      default: res = stg_r[DW+1].direct;
    endcase
    stg_nxt[DW+2].direct = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) stg_r[i].valid <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < NS; i++) stg_r[i] <= stg_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] v;
    q24a_pkg::out_item_t e0, e1;
    v  = skv_r;
    e0 = sk_r[0];
    e1 = sk_r[1];
    if (out_pop && v[0]) begin
      e0 = e1;
      v  = {1'b0, v[1]};
    end
    if (adv && last.valid) begin
      if (!v[0]) begin
        e0 = last.direct;
        v[0] = 1'b1;
      end else begin
        e1 = last.direct;
        v[1] = 1'b1;
      end
    end
    sk_r[0] <= e0;
    sk_r[1] <= e1;
    if (!rst_n) skv_r <= '0;
    else        skv_r <= v;
  end

endmodule
`default_nettype wire

/* tb/sv/q24a_alu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_alu_checker: result predictor and scoreboard for the Q24.8 ALU
// Watches both queue-style channels, computes the expected result of every
// accepted transfer and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module q24a_alu_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  input  wire                 in_full,
  input  q24a_pkg::in_item_t  in_item,
  input  wire                 out_pop,
  input  wire                 out_empty,
  input  q24a_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_results,
  output int                  results_seen
);

  localparam int FB = q24a_pkg::FRAC_BITS_DEF;

  q24a_pkg::out_item_t expected_results[$];

  function automatic q24a_pkg::out_item_t alu_predict(q24a_pkg::in_item_t it);
    q24a_pkg::out_item_t r;
    logic signed [63:0]  a;
    logic signed [63:0]  b;
    logic signed [63:0]  p;
    r = '0;
    a = it.operand_a;
    b = it.operand_b;
    case (q24a_pkg::opcode_t'(it.opcode))
      q24a_pkg::OP_ADD:  r.value = 32'(a + b);
      q24a_pkg::OP_SUB:  r.value = 32'(a - b);
      q24a_pkg::OP_MUL: begin
        p = a * b + (64'sd1 <<< (FB - 1));
        r.value = 32'(p >>> FB);
      end
      q24a_pkg::OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          p = (a <<< FB) / b;
          r.value = 32'(p);
        end
      end
      q24a_pkg::OP_GT:   r.compare_true = a > b;
      q24a_pkg::OP_LT:   r.compare_true = a < b;
      q24a_pkg::OP_GE:   r.compare_true = a >= b;
      q24a_pkg::OP_LE:   r.compare_true = a <= b;
      q24a_pkg::OP_EQ:   r.compare_true = a == b;
      q24a_pkg::OP_NE:   r.compare_true = a != b;
      q24a_pkg::OP_INC:  r.value = 32'(a + 64'sd1);
      q24a_pkg::OP_DEC:  r.value = 32'(a - 64'sd1);
      q24a_pkg::OP_MIN:  r.value = 32'((a <= b) ? a : b);
      q24a_pkg::OP_MAX:  r.value = 32'((a >= b) ? a : b);
      q24a_pkg::OP_TOINT: r.value = 32'(a >>> FB);
      default: r.value = it.operand_a <<< FB;
    endcase
    return r;
  endfunction

  assign pending_results = expected_results.size();

  always @(posedge clk) begin
    q24a_pkg::out_item_t want;
    if (!rst_n) begin
      expected_results.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (in_push && !in_full)
        expected_results.push_back(alu_predict(in_item));
      if (out_pop && !out_empty) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result %h", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_item) begin
            if (fail_count < 10)
              $display("ERROR: result mismatch: expected v=%h c=%b z=%b, got v=%h c=%b z=%b",
                       want.value, want.compare_true, want.divide_by_zero,
                       out_item.value, out_item.compare_true, out_item.divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_q24_8_fixed_point_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q24_8_fixed_point_alu: stimulus and verdict for the Q24.8 ALU
// Drives directed corner operands for every opcode, then mostly random
// transfers with random idling on both sides, a long receiver hold-off and
// a full drain pause; the checker module does all the prediction.
// ----------------------------------------------------------------------------
module tb_q24_8_fixed_point_alu;

  localparam int RANDOM_ITEMS = 1030;
  localparam int DRAIN_CYCLES = 80;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  q24a_pkg::in_item_t  in_item = '0;
  logic                in_full;
  q24a_pkg::out_item_t out_item;
  logic                out_empty;
  logic                out_pop = 1'b0;
  int                  fail_count;
  int                  pending_results;
  int                  results_seen;
  // Receiver behaviour, set by the stimulus process.
  bit                  sink_steady = 1'b0;
  int                  sink_hold_cycles = 0;

  always #5 clk = ~clk;

  q24_8_fixed_point_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_item(out_item), .out_empty(out_empty), .out_pop(out_pop)
  );

  q24a_alu_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item),
    .fail_count(fail_count), .pending_results(pending_results),
    .results_seen(results_seen)
  );

  // Pick an operand biased towards the corners and towards values whose
  // products and quotients stay interesting.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Offer one item at the falling edge and hold it until it is taken;
  // push stays high so the next item can follow without a gap.
  task automatic send_item(q24a_pkg::opcode_t op, logic [31:0] a, logic [31:0] b);
    in_item.opcode    <= op;
    in_item.operand_a <= a;
    in_item.operand_b <= b;
    in_push           <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Receiver: pops at random, except during a steady stretch or hold-off.
  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      out_pop <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else begin
      out_pop <= sink_steady || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] corners[6];
    int          waited;
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h100};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode once with corner pairs, then special cases.
    for (int op = 0; op < 16; op++)
      send_item(q24a_pkg::opcode_t'(op), corners[op % 6], corners[(op + 3) % 6]);
    send_item(q24a_pkg::OP_DIV, 32'h0000_0300, 32'h0);           // divide by zero
    send_item(q24a_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);   // quotient wraps
    send_item(q24a_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);   // negative quotient
    send_item(q24a_pkg::OP_MUL, 32'h0000_0080, 32'h0000_0001);   // exact half rounds up
    send_item(q24a_pkg::OP_MUL, 32'hffff_ff80, 32'h0000_0001);   // negative half
    send_item(q24a_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);   // product wraps
    send_item(q24a_pkg::OP_MIN, 32'h0000_1234, 32'h0000_1234);   // tie keeps operand_a
    send_item(q24a_pkg::OP_TOINT, 32'hffff_ff01, 32'h0);         // floor of negative
    send_item(q24a_pkg::OP_EQ, 32'h5555_5555, 32'h5555_5555);

    // Random part with gaps; a steady stretch, a hold-off and a drain pause.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sink_steady = (i >= 300 && i < 450);
      if (i == 600)
        sink_hold_cycles <= 200;
      if (i == 800) begin
        in_push <= 1'b0;
        @(negedge clk);
        waited = 0;
        while (pending_results != 0 && waited < 100_000) begin
          @(negedge clk);
          waited++;
        end
      end else if (!sink_steady && $urandom_range(0, 99) < 13) begin
        in_push <= 1'b0;
        @(negedge clk);
      end
      send_item(q24a_pkg::opcode_t'($urandom_range(0, 15)), pick_operand(),
                pick_operand());
    end
    in_push <= 1'b0;
    sink_steady = 1'b0;

    waited = 0;
    while (pending_results != 0 && waited < 100_000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d transfers over all sixteen opcodes, %0d results checked.",
             RANDOM_ITEMS + 25, results_seen);
    $display("Included corner operands, divide by zero, full-queue stall and drain pause.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/q24a_pkg.sv
src/q24a_front.sv
src/q24a_queue.sv
src/q24a_back.sv
src/q24_8_fixed_point_alu.sv
tb/sv/q24a_alu_checker.sv
tb/sv/tb_q24_8_fixed_point_alu.sv
